>>> src/fpv_pkg.sv
// shared types, constants and the byte-wide crc step for the framed payload validator
// no dependencies; every other file imports it
package fpv_pkg;

  // defaults and fixed frame layout
  localparam int unsigned MAX_REQUEST_BYTES_DEF = 65535;
  localparam int unsigned HEADER_BYTES          = 28;
  localparam int unsigned QUEUE_DEPTH           = 4;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [7:0]  JSON_OPEN     = 8'h7B;
  localparam logic [31:0] MAGIC_RESET   = 32'h5248_5044;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;

  // verdict codes
  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_JSON      = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_MAGIC     = 3'd3,
    ST_VERSION   = 3'd4,
    ST_SIZE      = 3'd5,
    ST_CRC       = 3'd6,
    ST_TOO_LONG  = 3'd7
  } status_t;

  // where a byte goes in the back end
  typedef enum logic [2:0] {
    FLD_NONE    = 3'd0,
    FLD_MAGIC   = 3'd1,
    FLD_VERSION = 3'd2,
    FLD_SIZE    = 3'd3,
    FLD_FLAGS   = 3'd4,
    FLD_STAMP   = 3'd5,
    FLD_CRC     = 3'd6,
    FLD_PAYLOAD = 3'd7
  } field_t;

  // classified byte queued between front and back
  typedef struct packed {
    logic [7:0] data;
    field_t     fld;
    logic [2:0] lane;
    logic       last;
    logic       too_long;
    logic       json;
    logic       too_small;
    logic       size_bad;
  } item_t;

  // one verdict
  typedef struct packed {
    status_t     status;
    logic [31:0] payload_size;
    logic [31:0] frame_flags;
    logic [63:0] frame_timestamp;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32, one byte, eight bit steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> src/fpv_if.sv
// valid/ready channel interfaces for request bytes and verdicts
// depends on fpv_pkg
interface fpv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fpv_out_if;
  import fpv_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] payload_size;
  logic [31:0] frame_flags;
  logic [63:0] frame_timestamp;
  logic [31:0] computed_crc;

  modport source (output valid, output status, output payload_size, output frame_flags,
                  output frame_timestamp, output computed_crc, input ready);
  modport sink   (input valid, input status, input payload_size, input frame_flags,
                  input frame_timestamp, input computed_crc, output ready);
endinterface

>>> src/framed_payload_validator_core.sv
// a final byte is queued, then its verdict is registered in the result register
// throughput: one byte per cycle unless the queue is full; byte-wide crc sets the pace
// a waiting verdict stalls only the next final byte; other bytes fill the 4-entry queue
// reset: synchronous active-low rst_n clears the byte count, frame fields and result valid,
// and restores the expected magic and version registers to their defaults
module framed_payload_validator_core #(
  parameter int unsigned MAX_REQUEST_BYTES = fpv_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fpv_in_if.sink                           in_ch,
  fpv_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fpv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fpv_pkg::*;

  localparam int unsigned ITEM_W = $bits(item_t);

  logic [31:0] exp_magic_r, exp_version_r;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  item_t       push_item, pop_item;
  logic [ITEM_W-1:0] pop_bits;
  result_t     res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r   <= MAGIC_RESET;
      exp_version_r <= VERSION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:   exp_magic_r   <= cfg_wdata;
        CFG_VERSION: exp_version_r <= cfg_wdata;
        default:     exp_magic_r   <= exp_magic_r;
      endcase
    end
  end

  // byte classifier
  fpv_front #(
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data_byte),
    .in_last   (in_ch.last_byte),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  // decoupling queue
  fpv_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_bits)
  );

  assign pop_item = item_t'(pop_bits);

  // field capture, crc and verdict
  fpv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .exp_magic  (exp_magic_r),
    .exp_version(exp_version_r),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  // result channel payload
  assign out_ch.status          = res.status;
  assign out_ch.payload_size    = res.payload_size;
  assign out_ch.frame_flags     = res.frame_flags;
  assign out_ch.frame_timestamp = res.frame_timestamp;
  assign out_ch.computed_crc    = res.computed_crc;

endmodule

>>> src/fpv_queue.sv
// short flop queue that decouples the classifier from the back end
// depends on fpv_pkg for defaults only
module fpv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = fpv_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import fpv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/fpv_front.sv
// front end: counts request bytes, tracks size field, classifies each byte
// depends on fpv_pkg
module fpv_front #(
  parameter int unsigned MAX_REQUEST_BYTES = fpv_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data,
  input  logic          in_last,
  output logic          push_valid,
  input  logic          push_ready,
  output fpv_pkg::item_t push_item
);
  import fpv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_REQUEST_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic             ovf_r, ovf_nxt;
  logic             json_r, json_nxt;
  logic [31:0]      size_r, size_nxt;
  logic             drop, in_hdr, take;
  logic [31:0]      pay_idx;
  field_t           fld;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  // classify the byte by its position in the request
  always_comb begin
    drop    = (cnt_r == CNT_W'(MAX_REQUEST_BYTES));
    in_hdr  = (cnt_r < CNT_W'(HEADER_BYTES));
    pay_idx = 32'(cnt_r) - 32'(HEADER_BYTES);
    fld     = FLD_NONE;
    if (drop) begin
      fld = FLD_NONE;
    end else if (in_hdr) begin
      case (cnt_r[4:2])
        3'd0:    fld = FLD_MAGIC;
        3'd1:    fld = FLD_VERSION;
        3'd2:    fld = FLD_SIZE;
        3'd3:    fld = FLD_FLAGS;
        3'd4:    fld = FLD_STAMP;
        3'd5:    fld = FLD_STAMP;
        3'd6:    fld = FLD_CRC;
        default: fld = FLD_NONE;
      endcase
    end else if (pay_idx < size_r) begin
      fld = FLD_PAYLOAD;
    end
  end

  // running frame state after this byte
  always_comb begin
    size_nxt = size_r;
    if (fld == FLD_SIZE) begin
      size_nxt[8*cnt_r[1:0] +: 8] = in_data;
    end
    ovf_nxt   = ovf_r | drop;
    json_nxt  = json_r | (!drop && (cnt_r == '0) && (in_data == JSON_OPEN));
    cnt_after = drop ? cnt_r : cnt_r + 1'b1;
    cnt_nxt   = cnt_after;
  end

  // queued item; verdict flags matter on the final byte only
  always_comb begin
    push_item.data      = in_data;
    push_item.fld       = fld;
    push_item.lane      = cnt_r[2:0];
    push_item.last      = in_last;
    push_item.too_long  = ovf_nxt;
    push_item.json      = json_nxt;
    push_item.too_small = (cnt_after < CNT_W'(HEADER_BYTES));
    push_item.size_bad  = (size_nxt > (32'(cnt_after) - 32'(HEADER_BYTES)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      json_r <= 1'b0;
      size_r <= '0;
    end else if (take) begin
      if (in_last) begin
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        json_r <= 1'b0;
        size_r <= '0;
      end else begin
        cnt_r  <= cnt_nxt;
        ovf_r  <= ovf_nxt;
        json_r <= json_nxt;
        size_r <= size_nxt;
      end
    end
  end

endmodule

>>> src/fpv_back.sv
// back end: captures header fields, runs the payload crc, forms the verdict
// depends on fpv_pkg
module fpv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  fpv_pkg::item_t   pop_item,
  input  logic [31:0]      exp_magic,
  input  logic [31:0]      exp_version,
  output logic             res_valid,
  input  logic             res_ready,
  output fpv_pkg::result_t res
);
  import fpv_pkg::*;

  logic [31:0] magic_r, magic_nxt;
  logic [31:0] version_r, version_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] flags_r, flags_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [31:0] crcx_r, crcx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        res_valid_r;
  result_t     res_r, res_nxt;
  logic        take;

  assign res_valid = res_valid_r;
  assign res       = res_r;
  // a final byte waits until the result register is free or being drained
  assign pop_ready = !pop_item.last || !res_valid_r || res_ready;
  assign take      = pop_valid && pop_ready;

  // place the byte in its field or feed it to the crc
  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    size_nxt    = size_r;
    flags_nxt   = flags_r;
    stamp_nxt   = stamp_r;
    crcx_nxt    = crcx_r;
    crc_nxt     = crc_r;
    case (pop_item.fld)
      FLD_MAGIC:   magic_nxt[8*pop_item.lane[1:0] +: 8]   = pop_item.data;
      FLD_VERSION: version_nxt[8*pop_item.lane[1:0] +: 8] = pop_item.data;
      FLD_SIZE:    size_nxt[8*pop_item.lane[1:0] +: 8]    = pop_item.data;
      FLD_FLAGS:   flags_nxt[8*pop_item.lane[1:0] +: 8]   = pop_item.data;
      FLD_STAMP:   stamp_nxt[8*pop_item.lane +: 8]        = pop_item.data;
      FLD_CRC:     crcx_nxt[8*pop_item.lane[1:0] +: 8]    = pop_item.data;
      FLD_PAYLOAD: crc_nxt = crc_byte(crc_r, pop_item.data);
      default:     crc_nxt = crc_r;
    endcase
  end

  // verdict in priority order
  always_comb begin
    res_nxt.payload_size    = size_nxt;
    res_nxt.frame_flags     = flags_nxt;
    res_nxt.frame_timestamp = stamp_nxt;
    res_nxt.computed_crc    = ~crc_nxt;
    if (pop_item.too_long) begin
      res_nxt.status = ST_TOO_LONG;
    end else if (pop_item.json) begin
      res_nxt.status = ST_JSON;
    end else if (pop_item.too_small) begin
      res_nxt.status = ST_TOO_SMALL;
    end else if (magic_nxt != exp_magic) begin
      res_nxt.status = ST_MAGIC;
    end else if (version_nxt != exp_version) begin
      res_nxt.status = ST_VERSION;
    end else if (pop_item.size_bad) begin
      res_nxt.status = ST_SIZE;
    end else if (~crc_nxt != crcx_nxt) begin
      res_nxt.status = ST_CRC;
    end else begin
      res_nxt.status = ST_VALID;
    end
  end

  // frame state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
      size_r    <= '0;
      flags_r   <= '0;
      stamp_r   <= '0;
      crcx_r    <= '0;
      crc_r     <= CRC_INIT;
    end else if (take) begin
      if (pop_item.last) begin
        magic_r   <= '0;
        version_r <= '0;
        size_r    <= '0;
        flags_r   <= '0;
        stamp_r   <= '0;
        crcx_r    <= '0;
        crc_r     <= CRC_INIT;
      end else begin
        magic_r   <= magic_nxt;
        version_r <= version_nxt;
        size_r    <= size_nxt;
        flags_r   <= flags_nxt;
        stamp_r   <= stamp_nxt;
        crcx_r    <= crcx_nxt;
        crc_r     <= crc_nxt;
      end
    end
  end

  // result register handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take && pop_item.last) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && pop_item.last) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> src/fpv_checker.sv
// port-level checks on the validator core, attached by bind
// depends on fpv_pkg and framed_payload_validator_core
module fpv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_payload_size,
  input logic [31:0] out_computed_crc
);
  import fpv_pkg::*;

  // reset drops any pending verdict
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict valid after reset");

  // a stalled verdict stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // a stalled verdict keeps its status
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status))
    else $error("verdict status changed while stalled");

  // a valid frame with empty payload has a crc of zero
  a_empty_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_VALID) && (out_payload_size == 32'd0)
      |-> (out_computed_crc == 32'd0))
    else $error("empty payload accepted with nonzero crc");

endmodule

bind framed_payload_validator_core fpv_checker u_fpv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_payload_size(out_ch.payload_size),
  .out_computed_crc(out_ch.computed_crc)
);

>>> verif/testbench.sv
// self-checking testbench for framed_payload_validator_core: byte requests in, verdicts out
// depends on fpv_pkg and the fpv_in_if / fpv_out_if channel interfaces
`timescale 1ns / 100ps

// tracks frame state per accepted byte and holds the verdicts still to come
class verdict_scoreboard;
  int unsigned          max_bytes;
  int unsigned          errors;
  logic [31:0]          magic_cfg;
  logic [31:0]          version_cfg;
  int unsigned          byte_cnt;
  bit                   overflow_seen;
  bit                   json_seen;
  logic [31:0]          magic_hdr;
  logic [31:0]          version_hdr;
  logic [31:0]          size_hdr;
  logic [31:0]          flags_hdr;
  logic [63:0]          stamp_hdr;
  logic [31:0]          crc_hdr;
  logic [31:0]          crc_acc;
  fpv_pkg::result_t     pending_verdicts[$];

  function new(int unsigned max_len);
    max_bytes   = max_len;
    errors      = 0;
    magic_cfg   = fpv_pkg::MAGIC_RESET;
    version_cfg = fpv_pkg::VERSION_RESET;
    clear_frame();
  endfunction

  function void clear_frame();
    byte_cnt      = 0;
    overflow_seen = 0;
    json_seen     = 0;
    magic_hdr     = '0;
    version_hdr   = '0;
    size_hdr      = '0;
    flags_hdr     = '0;
    stamp_hdr     = '0;
    crc_hdr       = '0;
    crc_acc       = fpv_pkg::CRC_INIT;
  endfunction

  function int unsigned pending();
    return pending_verdicts.size();
  endfunction

  function void set_register(logic [fpv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    if (idx == fpv_pkg::CFG_MAGIC) magic_cfg = val;
    else if (idx == fpv_pkg::CFG_VERSION) version_cfg = val;
  endfunction

  // reflected crc-32, one data bit per step, lsb first
  function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ fpv_pkg::CRC_POLY;
    end
    return r;
  endfunction

  // place one byte of the frame by its position
  function void store_byte(int unsigned idx, logic [7:0] b);
    int unsigned sh;
    sh = (idx % 4) * 8;
    if (idx == 0 && b == fpv_pkg::JSON_OPEN) json_seen = 1;
    if (idx < 4) magic_hdr[sh +: 8] = b;
    else if (idx < 8) version_hdr[sh +: 8] = b;
    else if (idx < 12) size_hdr[sh +: 8] = b;
    else if (idx < 16) flags_hdr[sh +: 8] = b;
    else if (idx < 24) stamp_hdr[(idx - 16) * 8 +: 8] = b;
    else if (idx < fpv_pkg::HEADER_BYTES) crc_hdr[sh +: 8] = b;
    else if (idx - fpv_pkg::HEADER_BYTES < size_hdr) crc_acc = crc_step(crc_acc, b);
  endfunction

  // one accepted request byte; a final byte yields the expected verdict
  function void take_request_byte(logic [7:0] b, logic last);
    fpv_pkg::result_t exp;
    logic [31:0]      calc;
    if (byte_cnt >= max_bytes) overflow_seen = 1;
    else begin
      store_byte(byte_cnt, b);
      byte_cnt++;
    end
    if (!last) return;
    calc = ~crc_acc;
    if (overflow_seen) exp.status = fpv_pkg::ST_TOO_LONG;
    else if (json_seen) exp.status = fpv_pkg::ST_JSON;
    else if (byte_cnt < fpv_pkg::HEADER_BYTES) exp.status = fpv_pkg::ST_TOO_SMALL;
    else if (magic_hdr != magic_cfg) exp.status = fpv_pkg::ST_MAGIC;
    else if (version_hdr != version_cfg) exp.status = fpv_pkg::ST_VERSION;
    else if (size_hdr > byte_cnt - fpv_pkg::HEADER_BYTES) exp.status = fpv_pkg::ST_SIZE;
    else if (calc != crc_hdr) exp.status = fpv_pkg::ST_CRC;
    else exp.status = fpv_pkg::ST_VALID;
    exp.payload_size    = size_hdr;
    exp.frame_flags     = flags_hdr;
    exp.frame_timestamp = stamp_hdr;
    exp.computed_crc    = calc;
    pending_verdicts.push_back(exp);
    clear_frame();
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task compare(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task check_verdict(fpv_pkg::result_t got);
    fpv_pkg::result_t want;
    if (pending_verdicts.size() == 0) begin
      report($sformatf("verdict %0d with no request pending", got.status));
      return;
    end
    want = pending_verdicts.pop_front();
    compare("status", 64'(got.status), 64'(want.status));
    compare("payload_size", 64'(got.payload_size), 64'(want.payload_size));
    compare("frame_flags", 64'(got.frame_flags), 64'(want.frame_flags));
    compare("frame_timestamp", got.frame_timestamp, want.frame_timestamp);
    compare("computed_crc", 64'(got.computed_crc), 64'(want.computed_crc));
  endtask
endclass

module testbench;
  import fpv_pkg::*;

  localparam int unsigned MAX_BYTES    = MAX_REQUEST_BYTES_DEF;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 375;
  localparam int unsigned PHASE_FRAMES = 12;
  localparam int unsigned CRC_OFS      = HEADER_BYTES - 4;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fpv_in_if  in_ch();
  fpv_out_if out_ch();

  verdict_scoreboard sb;
  result_t           seen;
  logic [7:0]        frame_q[$];
  int unsigned       items_sent;
  int unsigned       frames_sent;
  int unsigned       burst_left;
  int unsigned       cycles;
  bit                gaps_on;
  bit                hold_req;

  framed_payload_validator_core #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // receiver: random stall pattern, or a long hold-off on request
  initial begin
    int unsigned left;
    int unsigned held;
    rx_mode_t    mode;
    left = 0;
    held = 0;
    mode = RX_OPEN;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) begin
          held = 0;
          hold_req = 0;
        end
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(4, 64);
        end
        left--;
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
          default:   out_ch.ready <= left[2];
        endcase
      end
    end
  end

  // verdict transfer monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.status          = out_ch.status;
      seen.payload_size    = out_ch.payload_size;
      seen.frame_flags     = out_ch.frame_flags;
      seen.frame_timestamp = out_ch.frame_timestamp;
      seen.computed_crc    = out_ch.computed_crc;
      sb.check_verdict(seen);
    end
  end

  function automatic void push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame_q.push_back(v[8*i +: 8]);
  endfunction

  // header plus random payload; crc field is the true crc xor crc_err
  function automatic void build_frame(input logic [31:0] magic, input logic [31:0] version,
                                      input logic [31:0] psize, input logic [31:0] flags,
                                      input logic [63:0] stamp, input int unsigned pay_len,
                                      input logic [31:0] crc_err);
    logic [31:0] crc;
    logic [7:0]  pb;
    frame_q.delete();
    push_le(magic, 4);
    push_le(version, 4);
    push_le(psize, 4);
    push_le(flags, 4);
    push_le(stamp, 8);
    push_le(64'd0, 4);
    crc = CRC_INIT;
    for (int unsigned i = 0; i < pay_len; i++) begin
      pb = $urandom_range(0, 255);
      frame_q.push_back(pb);
      if (i < psize) crc = sb.crc_step(crc, pb);
    end
    crc = ~crc ^ crc_err;
    for (int i = 0; i < 4; i++) frame_q[CRC_OFS + i] = crc[8*i +: 8];
  endfunction

  function automatic void build_noise(input int unsigned len);
    logic [7:0] pb;
    frame_q.delete();
    for (int unsigned i = 0; i < len; i++) begin
      pb = $urandom_range(0, 255);
      frame_q.push_back(pb);
    end
  endfunction

  // offer one byte in bursts with random gaps, return at its transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_request_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame();
    for (int unsigned i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // sender pauses until every verdict is in and the pipeline is empty
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [31:0] version);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_wdata <= version;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_MAGIC, magic);
    sb.set_register(CFG_VERSION, version);
  endtask

  task automatic run_directed();
    logic [31:0] mg;
    logic [31:0] vs;
    mg = MAGIC_RESET;
    vs = VERSION_RESET;
    // lone final bytes: zero, json open, all ones; then a longer noise request opening with json open
    build_noise(1); frame_q[0] = 8'h00; send_frame();
    build_noise(1); frame_q[0] = JSON_OPEN; send_frame();
    build_noise(1); frame_q[0] = 8'hFF; send_frame();
    build_noise(36); frame_q[0] = JSON_OPEN; send_frame();
    // header one byte short
    build_frame(mg, vs, 0, '1, '1, 0, 0);
    void'(frame_q.pop_back());
    send_frame();
    // empty payload, good and bad crc field
    build_frame(mg, vs, 0, 0, 0, 0, 0); send_frame();
    build_frame(mg, vs, 0, '1, '1, 0, '1); send_frame();
    // small payloads, with and without trailing bytes past the size
    build_frame(mg, vs, 4, $urandom, {$urandom, $urandom}, 4, 0); send_frame();
    build_frame(mg, vs, 20, $urandom, {$urandom, $urandom}, 23, 0); send_frame();
    // header rejects
    build_frame(~mg, vs, 8, $urandom, {$urandom, $urandom}, 8, 0); send_frame();
    build_frame(mg, vs + 1, 8, $urandom, {$urandom, $urandom}, 8, 0); send_frame();
    // size beyond the data, then a crc field off in its top bit
    build_frame(mg, vs, '1, $urandom, {$urandom, $urandom}, 5, 0); send_frame();
    build_frame(mg, vs, 9, $urandom, {$urandom, $urandom}, 8, 0); send_frame();
    build_frame(mg, vs, 12, $urandom, {$urandom, $urandom}, 12, 32'h8000_0000); send_frame();
    // longer request sent back to back with no gaps
    gaps_on = 0;
    build_frame(mg, vs, 200, $urandom, {$urandom, $urandom}, 200, 0);
    send_frame();
    gaps_on = 1;
    build_frame(mg, vs, 3, $urandom, {$urandom, $urandom}, 3, 0); send_frame();
  endtask

  // frames with random content, well-formed or broken, and noise
  task automatic random_frame();
    int unsigned pick;
    int unsigned pay;
    logic [31:0] psize;
    logic [31:0] mg;
    logic [31:0] vs;
    logic [31:0] err;
    pick  = $urandom_range(0, 99);
    mg    = sb.magic_cfg;
    vs    = sb.version_cfg;
    err   = '0;
    pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    psize = pay;
    if ($urandom_range(0, 3) == 0) pay += $urandom_range(1, 4);
    if (pick < 45) begin
    end else if (pick < 55) begin
      err = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
    end else if (pick < 62) begin
      psize = $urandom_range(0, 1) ? pay + $urandom_range(1, 3) : $urandom;
    end else if (pick < 69) begin
      mg ^= 32'h1 << $urandom_range(0, 31);
    end else if (pick < 76) begin
      vs ^= 32'h1 << $urandom_range(0, 31);
    end
    if (pick < 76) begin
      build_frame(mg, vs, psize, $urandom, {$urandom, $urandom}, pay, err);
    end else begin
      build_noise(pick < 88 ? $urandom_range(1, HEADER_BYTES - 1) : $urandom_range(1, 60));
      if (pick < 82) frame_q[0] = JSON_OPEN;
    end
    send_frame();
  endtask

  task automatic random_phase(input logic [31:0] magic, input logic [31:0] version,
                              input bit with_hold);
    int unsigned item0;
    int unsigned frame0;
    wait_idle();
    set_config(magic, version);
    item0  = items_sent;
    frame0 = frames_sent;
    // receiver holds off while short frames keep coming, so the input backs up
    if (with_hold) begin
      hold_req = 1;
      repeat (16) begin
        if ($urandom_range(0, 1) != 0) build_noise(1);
        else build_frame(magic, version, 0, $urandom, {$urandom, $urandom}, 0, 0);
        send_frame();
      end
    end
    while (items_sent - item0 < PHASE_ITEMS || frames_sent - frame0 < PHASE_FRAMES)
      random_frame();
  endtask

  // stimulus
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    items_sent  = 0;
    frames_sent = 0;
    burst_left  = 0;
    gaps_on     = 1;
    hold_req    = 0;
    sb = new(MAX_BYTES);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    random_phase(32'h0, 32'h0, 1);
    random_phase('1, '1, 0);
    random_phase($urandom, $urandom, 0);
    random_phase(MAGIC_RESET, $urandom_range(0, 3), 0);

    // drain, then keep watching to catch stray verdicts
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
    if (sb.errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
